// ===== rtl/texture_nearest_bilinear_sampler_top_macros.svh =====
// ----------------------------------------------------------------------------
// Sampler assertion macros
// Concurrent checks used by the texture sampler; empty when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef TEXTURE_NEAREST_BILINEAR_SAMPLER_TOP_MACROS_SVH
`define TEXTURE_NEAREST_BILINEAR_SAMPLER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define TNBS_ASSERT_IMPLIES(name, clk_s, rstn_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// next-cycle implication
`define TNBS_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`else

`define TNBS_ASSERT_IMPLIES(name, clk_s, rstn_s, ante, cons)
`define TNBS_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons)

`endif

`endif

// ===== rtl/tnbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Texture sampler package
// Shared types, codes, widths and helper functions of the texture sampler.
// ----------------------------------------------------------------------------
package tnbs_pkg;

	// texture geometry
	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int COORD_W    = $clog2(MAX_WIDTH);
	localparam int SIZE_W     = 7;
	localparam int TEXEL_W    = 32;

	// arithmetic widths
	localparam int FRAC_W   = 16;
	localparam int WT_W     = 33;
	localparam int ACC_W    = 40;
	localparam int NET_W    = 33;
	localparam int REM_W    = 32;
	localparam int NUM_W    = 48;
	localparam int DIV_BITS = 16;

	localparam logic [SIZE_W-1:0] SIZE_W_MAX = 7'(MAX_WIDTH);
	localparam logic [SIZE_W-1:0] SIZE_H_MAX = 7'(MAX_HEIGHT);
	localparam logic signed [31:0] HALF_TEXEL = 32'sd32768;
	localparam logic [FRAC_W:0]   WEIGHT_ONE = 17'h10000;
	localparam logic [15:0]       ONE_Q8     = 16'd65280;

	// operation codes
	localparam logic [1:0] OP_WRITE    = 2'd0;
	localparam logic [1:0] OP_NEAREST  = 2'd1;
	localparam logic [1:0] OP_BILINEAR = 2'd2;
	localparam logic [1:0] OP_UNUSED   = 2'd3;

	// register indexes
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_FORMAT = 2'd2;

	// texel formats
	localparam logic [3:0] FMT_R    = 4'd0;
	localparam logic [3:0] FMT_G    = 4'd1;
	localparam logic [3:0] FMT_B    = 4'd2;
	localparam logic [3:0] FMT_A    = 4'd3;
	localparam logic [3:0] FMT_LUM  = 4'd4;
	localparam logic [3:0] FMT_LA   = 4'd5;
	localparam logic [3:0] FMT_RG   = 4'd6;
	localparam logic [3:0] FMT_RGB  = 4'd7;
	localparam logic [3:0] FMT_RGBA = 4'd8;

	// component slots
	localparam int CH_R = 0;
	localparam int CH_G = 1;
	localparam int CH_B = 2;
	localparam int CH_A = 3;

	// bilinear issues four reads
	localparam logic [1:0] CORNER_LAST = 2'd3;

	typedef struct packed {
		logic [1:0]         op;
		logic [ADDR_W-1:0]  texel_addr;
		logic [TEXEL_W-1:0] texel_bytes;
		logic signed [23:0] coord_u;
		logic signed [23:0] coord_v;
	} tnbs_cmd_t;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [15:0] alpha;
		logic        hit;
	} tnbs_result_t;

	typedef struct packed {
		logic [3:0][ACC_W-1:0] acc;
		logic [NET_W-1:0]      net;
	} tnbs_div_in_t;

	typedef struct packed {
		logic                   zero;
		logic [3:0][FRAC_W-1:0] quo;
	} tnbs_div_out_t;

	// size register: zero means one, too large means the maximum
	function automatic logic [SIZE_W-1:0] tnbs_clamp_size(logic [SIZE_W-1:0] s,
		logic [SIZE_W-1:0] lim);
		logic [SIZE_W-1:0] r;
		if (s == '0) begin
			r = 7'd1;
		end else if (s > lim) begin
			r = lim;
		end else begin
			r = s;
		end
		return r;
	endfunction

	// stored word to four 0..255 components
	function automatic logic [3:0][7:0] tnbs_expand(logic [TEXEL_W-1:0] t, logic [3:0] fmt);
		logic [7:0]      b0, b1, b2, b3;
		logic [3:0][7:0] c;
		b0 = t[7:0];
		b1 = t[15:8];
		b2 = t[23:16];
		b3 = t[31:24];
		c  = '0;
		c[CH_A] = 8'hFF;
		case (fmt)
			FMT_R: c[CH_R] = b0;
			FMT_G: c[CH_G] = b0;
			FMT_B: c[CH_B] = b0;
			FMT_A: c[CH_A] = b0;
			FMT_LUM: begin
				c[CH_R] = b0;
				c[CH_G] = b0;
				c[CH_B] = b0;
			end
			FMT_LA: begin
				c[CH_R] = b0;
				c[CH_G] = b0;
				c[CH_B] = b0;
				c[CH_A] = b1;
			end
			FMT_RG: begin
				c[CH_R] = b0;
				c[CH_G] = b1;
			end
			FMT_RGB: begin
				c[CH_B] = b0;
				c[CH_G] = b1;
				c[CH_R] = b2;
			end
			default: begin
				// rgba and unused codes
				c[CH_B] = b0;
				c[CH_G] = b1;
				c[CH_R] = b2;
				c[CH_A] = b3;
			end
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/tnbs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module tnbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== rtl/tnbs_div.sv =====
// ----------------------------------------------------------------------------
// Sampler normalizing divider
// Rounds (acc*256 + net/2) / net for four channels, one quotient bit a stage.
// ----------------------------------------------------------------------------
module tnbs_div
	import tnbs_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  tnbs_div_in_t  in_data,
	output logic          out_valid,
	output tnbs_div_out_t out_data
);

	typedef struct packed {
		logic                   zero;
		logic [NET_W-1:0]       den;
		logic [3:0][REM_W-1:0]  rem;
		logic [3:0][FRAC_W-1:0] nlo;
		logic [3:0][FRAC_W-1:0] quo;
	} tnbs_dstage_t;

	logic         stage_v_s  [0:DIV_BITS];
	tnbs_dstage_t stage_d_s  [0:DIV_BITS];
	tnbs_dstage_t prep;

	// one restoring step for all channels
	function automatic tnbs_dstage_t div_step(tnbs_dstage_t s);
		tnbs_dstage_t  r;
		logic [REM_W:0] t;
		logic           ge;
		r = s;
		for (int k = 0; k < 4; k++) begin
			t  = {s.rem[k], s.nlo[k][FRAC_W-1]};
			ge = (t >= s.den);
			r.rem[k] = ge ? REM_W'(t - s.den) : t[REM_W-1:0];
			r.quo[k] = {s.quo[k][FRAC_W-2:0], ge};
			r.nlo[k] = {s.nlo[k][FRAC_W-2:0], 1'b0};
		end
		return r;
	endfunction

	// numerator with rounding term, split into leading remainder and low bits
	always_comb begin
		logic [NUM_W-1:0] numer;
		prep.zero = (in_data.net == '0);
		prep.den  = in_data.net;
		prep.quo  = '0;
		for (int k = 0; k < 4; k++) begin
			numer = {in_data.acc[k], 8'd0} + NUM_W'(in_data.net >> 1);
			prep.rem[k] = numer[NUM_W-1:FRAC_W];
			prep.nlo[k] = numer[FRAC_W-1:0];
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= DIV_BITS; i++) begin
				stage_v_s[i] <= 1'b0;
			end
		end else begin
			stage_v_s[0] <= in_valid;
			for (int i = 0; i < DIV_BITS; i++) begin
				stage_v_s[i+1] <= stage_v_s[i];
			end
		end
	end

	// data chain
	always_ff @(posedge clk) begin
		stage_d_s[0] <= prep;
		for (int i = 0; i < DIV_BITS; i++) begin
			stage_d_s[i+1] <= div_step(stage_d_s[i]);
		end
	end

	assign out_valid     = stage_v_s[DIV_BITS];
	assign out_data.zero = stage_d_s[DIV_BITS].zero;
	assign out_data.quo  = stage_d_s[DIV_BITS].quo;

endmodule

// ===== rtl/texture_nearest_bilinear_sampler_top.sv =====
// ----------------------------------------------------------------------------
// Texture nearest / bilinear sampler
// 2-D texel store with write, nearest and bilinear sample commands.
// ----------------------------------------------------------------------------
// channel   signals                                    direction
// command   start, busy, cmd                           in (accepted: start & !busy)
// result    done, result                               out (one-cycle strobe)
// config    cfg_valid, cfg_ready, cfg_index, cfg_data  in (cfg_ready always high)
//
// Writes and nearest samples take a single access of the texel RAM port, so
// one item per cycle while busy is low; a bilinear sample reads four texels
// through that single port and holds busy so that no new command reaches the
// port before its last read.
// Reset clears control and config (64 x 64, rgba); texel RAM is undefined
// until written. Results cannot be held off, so the pipeline never stalls.
// ----------------------------------------------------------------------------
`include "texture_nearest_bilinear_sampler_top_macros.svh"

module texture_nearest_bilinear_sampler_top
	import tnbs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  tnbs_cmd_t           cmd,
	output logic                done,
	output tnbs_result_t        result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [SIZE_W-1:0]   cfg_data
);

	// config registers
	logic [SIZE_W-1:0] w_q, h_q;
	logic [3:0]        fmt_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q   <= SIZE_W_MAX;
			h_q   <= SIZE_H_MAX;
			fmt_q <= FMT_RGBA;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WIDTH:  w_q   <= tnbs_clamp_size(cfg_data, SIZE_W_MAX);
				REG_HEIGHT: h_q   <= tnbs_clamp_size(cfg_data, SIZE_H_MAX);
				REG_FORMAT: fmt_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// command accept; bilinear blocks the port for its extra reads
	logic       accept;
	logic [1:0] busy_cnt_q;

	assign accept = start && !busy;
	assign busy   = (busy_cnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_cnt_q <= 2'd0;
		end else if (accept && cmd.op == OP_BILINEAR) begin
			busy_cnt_q <= CORNER_LAST;
		end else if (busy_cnt_q != 2'd0) begin
			busy_cnt_q <= busy_cnt_q - 2'd1;
		end
	end

	// stage 1: command register
	logic      v_s1;
	tnbs_cmd_t cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
	end

	// stage 1 logic: scale coordinates
	logic signed [31:0] u_scaled, v_scaled;
	logic [22:0]        nu_prod, nv_prod;
	logic [15:0]        mu_n, mv_n;

	assign u_scaled = $signed(cmd_s1.coord_u) * $signed({1'b0, w_q}) - HALF_TEXEL;
	assign v_scaled = $signed(cmd_s1.coord_v) * $signed({1'b0, h_q}) - HALF_TEXEL;
	assign nu_prod  = 23'(cmd_s1.coord_u[FRAC_W-1:0]) * 23'(w_q);
	assign nv_prod  = 23'(cmd_s1.coord_v[FRAC_W-1:0]) * 23'(h_q);

	// nearest: wrapped texel index; bilinear: floor of shifted coordinate
	assign mu_n = (cmd_s1.op == OP_BILINEAR) ? u_scaled[31:16]
		: 16'(nu_prod[FRAC_W+COORD_W-1:FRAC_W]);
	assign mv_n = (cmd_s1.op == OP_BILINEAR) ? v_scaled[31:16]
		: 16'(nv_prod[FRAC_W+COORD_W-1:FRAC_W]);

	// stage 2: RAM issue, one corner per cycle
	logic                v_s2;
	logic [1:0]          corner_q;
	logic [1:0]          op_s2;
	logic [15:0]         mu_s2, mv_s2;
	logic [FRAC_W-1:0]   fu_s2, fv_s2;
	logic [ADDR_W-1:0]   addr_s2;
	logic [TEXEL_W-1:0]  bytes_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2     <= 1'b0;
			corner_q <= 2'd0;
		end else if (v_s1) begin
			v_s2     <= 1'b1;
			corner_q <= 2'd0;
		end else if (v_s2 && op_s2 == OP_BILINEAR && corner_q != CORNER_LAST) begin
			corner_q <= corner_q + 2'd1;
		end else begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			op_s2    <= cmd_s1.op;
			mu_s2    <= mu_n;
			mv_s2    <= mv_n;
			fu_s2    <= u_scaled[FRAC_W-1:0];
			fv_s2    <= v_scaled[FRAC_W-1:0];
			addr_s2  <= cmd_s1.texel_addr;
			bytes_s2 <= cmd_s1.texel_bytes;
		end
	end

	// corner position, in-image test, weight and address
	logic                dx, dy;
	logic [15:0]         xx, yy;
	logic                in_img;
	logic [FRAC_W:0]     wx, wy;
	logic [33:0]         wt_full;
	logic [WT_W-1:0]     beat_wt;
	logic [ADDR_W-1:0]   addr_calc;
	logic                beat_v, beat_first, beat_last;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_addr;
	logic [TEXEL_W-1:0]  ram_rdata;

	assign dx = corner_q[0];
	assign dy = corner_q[1];
	assign xx = mu_s2 + 16'(dx);
	assign yy = mv_s2 + 16'(dy);

	assign in_img = !xx[15] && (xx < 16'(w_q)) && !yy[15] && (yy < 16'(h_q));

	assign wx      = dx ? {1'b0, fu_s2} : WEIGHT_ONE - {1'b0, fu_s2};
	assign wy      = dy ? {1'b0, fv_s2} : WEIGHT_ONE - {1'b0, fv_s2};
	assign wt_full = 34'(wx) * 34'(wy);
	assign beat_wt = !in_img ? '0
		: (op_s2 == OP_BILINEAR) ? wt_full[WT_W-1:0] : WT_W'(1);

	assign addr_calc = ADDR_W'(13'(yy[COORD_W-1:0]) * 13'(w_q) + 13'(xx[COORD_W-1:0]));

	assign beat_v     = v_s2 && (op_s2 == OP_NEAREST || op_s2 == OP_BILINEAR);
	assign beat_first = (corner_q == 2'd0);
	assign beat_last  = (op_s2 != OP_BILINEAR) || (corner_q == CORNER_LAST);

	assign ram_we   = v_s2 && (op_s2 == OP_WRITE);
	assign ram_addr = ram_we ? addr_s2 : addr_calc;

	tnbs_ram #(
		.WIDTH(TEXEL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (bytes_s2),
		.rdata (ram_rdata)
	);

	// stage 3: texel arrives, expand and weight
	logic            v_s3, first_s3, last_s3, in_s3;
	logic [WT_W-1:0] wt_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= beat_v;
		end
	end

	always_ff @(posedge clk) begin
		first_s3 <= beat_first;
		last_s3  <= beat_last;
		in_s3    <= in_img;
		wt_s3    <= beat_wt;
	end

	logic [3:0][7:0]       comp;
	logic [3:0][ACC_W-1:0] prod;

	always_comb begin
		comp = in_s3 ? tnbs_expand(ram_rdata, fmt_q) : '0;
		for (int k = 0; k < 4; k++) begin
			prod[k] = ACC_W'(comp[k]) * ACC_W'(wt_s3);
		end
	end

	// stage 4: products, then accumulate over the corners
	logic                  v_s4, first_s4, last_s4;
	logic [3:0][ACC_W-1:0] prod_s4;
	logic [WT_W-1:0]       wt_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		first_s4 <= first_s3;
		last_s4  <= last_s3;
		prod_s4  <= prod;
		wt_s4    <= wt_s3;
	end

	logic [3:0][ACC_W-1:0] acc_q, acc_sum;
	logic [NET_W-1:0]      net_q, net_sum;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			acc_sum[k] = (first_s4 ? '0 : acc_q[k]) + prod_s4[k];
		end
		net_sum = (first_s4 ? '0 : net_q) + NET_W'(wt_s4);
	end

	always_ff @(posedge clk) begin
		if (v_s4) begin
			acc_q <= acc_sum;
			net_q <= net_sum;
		end
	end

	// stage 5: sums to the divider
	logic         div_v_s5;
	tnbs_div_in_t div_in_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v_s5 <= 1'b0;
		end else begin
			div_v_s5 <= v_s4 && last_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4 && last_s4) begin
			div_in_s5.acc <= acc_sum;
			div_in_s5.net <= net_sum;
		end
	end

	logic          div_v;
	tnbs_div_out_t div_out;

	tnbs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_v_s5),
		.in_data   (div_in_s5),
		.out_valid (div_v),
		.out_data  (div_out)
	);

	// result register; no covered texel gives black with hit low
	logic         done_q;
	tnbs_result_t result_q;

	function automatic logic [15:0] sat_q8(logic [FRAC_W-1:0] q, logic zero);
		logic [15:0] r;
		if (zero) begin
			r = 16'd0;
		end else if (q > ONE_Q8) begin
			r = ONE_Q8;
		end else begin
			r = q;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_v;
		end
	end

	always_ff @(posedge clk) begin
		result_q.red   <= sat_q8(div_out.quo[CH_R], div_out.zero);
		result_q.green <= sat_q8(div_out.quo[CH_G], div_out.zero);
		result_q.blue  <= sat_q8(div_out.quo[CH_B], div_out.zero);
		result_q.alpha <= sat_q8(div_out.quo[CH_A], div_out.zero);
		result_q.hit   <= !div_out.zero;
	end

	assign done   = done_q;
	assign result = result_q;

	// checks
	logic res_black, res_in_range;

	assign res_black = (result.red == 16'd0) && (result.green == 16'd0)
		&& (result.blue == 16'd0) && (result.alpha == 16'd0);
	assign res_in_range = (result.red <= ONE_Q8) && (result.green <= ONE_Q8)
		&& (result.blue <= ONE_Q8) && (result.alpha <= ONE_Q8);

	`TNBS_ASSERT_NEXT(a_bil_holds_port, clk, arst_n, accept && cmd.op == OP_BILINEAR, busy)
	`TNBS_ASSERT_IMPLIES(a_miss_black, clk, arst_n, done && !result.hit, res_black)
	`TNBS_ASSERT_IMPLIES(a_color_range, clk, arst_n, done, res_in_range)

endmodule
